[rtl/core/percent_url_utf8_decoder_assert.svh]
// ----------------------------------------------------------------------------
// percent_url_utf8_decoder assertion macros
// Concurrent checks sampled on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERCENT_URL_UTF8_DECODER_ASSERT_SVH
`define PERCENT_URL_UTF8_DECODER_ASSERT_SVH

// same-cycle implication
`define PUD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PUD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/pud_pkg.sv]
// ----------------------------------------------------------------------------
// pud_pkg
// Types, codes and helpers shared by the percent/UTF-8 decoder.
// ----------------------------------------------------------------------------
package pud_pkg;

	localparam logic [7:0] PCT_CHAR = 8'h25;
	localparam logic [4:0] HEX_NONE = 5'h10;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HI   = 2'd1;
	localparam logic [1:0] PH_LO   = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       end_of_uri;
		logic       status;
	} out_t;

	typedef struct packed {
		logic [1:0] phase;
		logic [3:0] high_nibble;
		logic [1:0] pending;
		logic       failed;
	} state_t;

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = HEX_NONE;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			v = {1'b0, c[3:0] + 4'd9};
		end
		return v;
	endfunction

endpackage

[rtl/core/percent_url_utf8_decoder.sv]
// ----------------------------------------------------------------------------
// percent_url_utf8_decoder
// Each result is registered in the result register or its skid entry.
// Throughput: one byte per cycle; the per-byte decode sits between the
// decode state and the result register, so stalls only come from the output.
// Input stalls only when the result register and its skid entry are both full.
// Reset (arst_n low) clears decode state and drops any pending results.
// ----------------------------------------------------------------------------
`include "percent_url_utf8_decoder_assert.svh"

module percent_url_utf8_decoder (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	output logic          byte_stall,
	input  pud_pkg::in_t  byte_data,
	output logic          res_valid,
	input  logic          res_stall,
	output pud_pkg::out_t res_data
);

	pud_pkg::state_t state_q;
	pud_pkg::state_t state_nxt;
	pud_pkg::out_t   step_res;
	logic            step_has;
	logic            accept;

	assign accept = byte_valid & ~byte_stall;

	pud_step u_step (
		.cur        (state_q),
		.item       (byte_data),
		.nxt        (state_nxt),
		.has_result (step_has),
		.res        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	pud_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept & step_has),
		.push_data (step_res),
		.full      (byte_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	`PUD_ASSERT_NEXT(a_last_clears, accept && byte_data.in_last, state_q == '0, "state kept after end")
	`PUD_ASSERT_NOW(a_bad_end_quiet, res_valid && res_data.status, !res_data.out_valid && res_data.end_of_uri, "malformed end carries a byte")
	`PUD_ASSERT_NOW(a_mid_has_byte, res_valid && !res_data.end_of_uri, res_data.out_valid && !res_data.status, "empty mid-stream result")

endmodule

[rtl/core/pud_step.sv]
// ----------------------------------------------------------------------------
// pud_step
// Per-byte decode: next state and the result for one item.
// ----------------------------------------------------------------------------
module pud_step (
	input  pud_pkg::state_t cur,
	input  pud_pkg::in_t    item,
	output pud_pkg::state_t nxt,
	output logic            has_result,
	output pud_pkg::out_t   res
);

	logic [4:0] hv;
	logic [7:0] x;
	logic       emit;
	logic [7:0] val;
	pud_pkg::state_t upd;

	assign hv = pud_pkg::hex_value(item.in_byte);
	assign x  = {cur.high_nibble, hv[3:0]};

	always_comb begin
		upd  = cur;
		emit = 1'b0;
		val  = 8'd0;
		if (!cur.failed) begin
			unique case (cur.phase)
				pud_pkg::PH_HI: begin
					if (hv[4]) begin
						upd.failed = 1'b1;
					end else begin
						upd.high_nibble = hv[3:0];
						upd.phase       = pud_pkg::PH_LO;
					end
				end
				pud_pkg::PH_LO: begin
					if (hv[4]) begin
						upd.failed = 1'b1;
					end else begin
						upd.phase = pud_pkg::PH_IDLE;
						val       = x;
						priority if (cur.pending != 2'd0) begin
							if (x[7:6] != 2'b10) begin
								upd.failed = 1'b1;
							end else begin
								upd.pending = cur.pending - 2'd1;
								emit        = 1'b1;
							end
						end else if (!x[7]) begin
							emit = 1'b1;
						end else if (x[7:6] == 2'b10) begin
							upd.failed = 1'b1;
						end else if (x[7:5] == 3'b110) begin
							upd.pending = 2'd1;
							emit        = 1'b1;
						end else if (x[7:4] == 4'b1110) begin
							upd.pending = 2'd2;
							emit        = 1'b1;
						end else if (x[7:3] == 5'b11110) begin
							upd.pending = 2'd3;
							emit        = 1'b1;
						end else begin
							upd.failed = 1'b1;
						end
					end
				end
				default: begin
					priority if (item.in_byte == pud_pkg::PCT_CHAR) begin
						upd.phase = pud_pkg::PH_HI;
					end else if (cur.pending != 2'd0) begin
						upd.failed = 1'b1;
					end else begin
						upd.phase = pud_pkg::PH_IDLE;
						emit      = 1'b1;
						val       = item.in_byte;
					end
				end
			endcase
			if (item.in_last && !upd.failed
			    && (upd.phase != pud_pkg::PH_IDLE || upd.pending != 2'd0)) begin
				upd.failed = 1'b1;
			end
		end
		if (upd.failed) begin
			emit = 1'b0;
		end
	end

	always_comb begin
		res.out_byte   = emit ? val : 8'd0;
		res.out_valid  = emit;
		res.end_of_uri = item.in_last;
		res.status     = item.in_last & upd.failed;
		has_result     = emit | item.in_last;
		nxt            = item.in_last ? '0 : upd;
	end

endmodule

[rtl/core/pud_out_buf.sv]
// ----------------------------------------------------------------------------
// pud_out_buf
// Result register with a skid entry; upstream stalls only when both are full.
// ----------------------------------------------------------------------------
`include "percent_url_utf8_decoder_assert.svh"

module pud_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pud_pkg::out_t push_data,
	output logic          full,
	output logic          res_valid,
	input  logic          res_stall,
	output pud_pkg::out_t res_data
);

	logic          main_v_q;
	pud_pkg::out_t main_q;
	logic          skid_v_q;
	pud_pkg::out_t skid_q;
	logic          take;

	assign take      = main_v_q & ~res_stall;
	assign full      = skid_v_q;
	assign res_valid = main_v_q;
	assign res_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || take) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || take) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	`PUD_ASSERT_NOW(a_skid_needs_main, skid_v_q, main_v_q, "skid entry without result entry")
	`PUD_ASSERT_NEXT(a_skid_fill, main_v_q && res_stall && push, skid_v_q, "item lost on stall")
	`PUD_ASSERT_NEXT(a_skid_drain, skid_v_q && !res_stall, !skid_v_q, "skid entry not drained")

endmodule
